>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/rrv_pkg.sv
package rrv_pkg;

  // Angle reduction in Q.6 degrees
  localparam int unsigned TURN_Q6    = 23040;
  localparam int unsigned QUARTER_Q6 = 5760;
  // Q.6 degrees to Q30 radians
  localparam logic [18:0] DEG_TO_RAD_Q30 = 19'd292818;
  // Inverse CORDIC gain in Q30
  localparam longint GAIN_Q30 = 64'sd652032874;

  localparam int COORD_W = 24;
  localparam int SIZE_W  = 23;
  localparam int ANGLE_W = 16;
  // local offsets and pivot, one bit wider than coordinates
  localparam int LOC_W   = 25;
  localparam int Z_W     = 33;

  // Corner codes
  localparam logic [1:0] VTX_LT = 2'd0;
  localparam logic [1:0] VTX_RT = 2'd1;
  localparam logic [1:0] VTX_LB = 2'd2;
  localparam logic [1:0] VTX_RB = 2'd3;

  // Geometry that rides along the angle pipeline
  typedef struct packed {
    logic signed [LOC_W-1:0] ox;
    logic signed [LOC_W-1:0] oy;
    logic signed [LOC_W-1:0] lx_l;
    logic signed [LOC_W-1:0] lx_r;
    logic signed [LOC_W-1:0] ly_t;
    logic signed [LOC_W-1:0] ly_b;
  } geom_t;

  // Arctangent of 2^-i in Q30 radians
  function automatic logic [30:0] atan_q30(input int unsigned i);
    logic [30:0] r;
    case (i)
      0:  r = 31'd843314856;
      1:  r = 31'd497837829;
      2:  r = 31'd263043836;
      3:  r = 31'd133525158;
      4:  r = 31'd67021686;
      5:  r = 31'd33543515;
      6:  r = 31'd16775850;
      7:  r = 31'd8388437;
      8:  r = 31'd4194282;
      9:  r = 31'd2097149;
      10: r = 31'd1048575;
      11: r = 31'd524287;
      12: r = 31'd262143;
      13: r = 31'd131071;
      14: r = 31'd65535;
      15: r = 31'd32767;
      16: r = 31'd16383;
      17: r = 31'd8191;
      18: r = 31'd4095;
      19: r = 31'd2047;
      20: r = 31'd1023;
      21: r = 31'd511;
      22: r = 31'd255;
      23: r = 31'd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rotated_rect_vertices.sv
// Rotated rectangle corner generator. A rectangle word is taken when start is
// high and busy is low; four corner words follow on vertex_valid_o, one per
// cycle, in the order left-top, right-top, left-bottom, right-bottom, the last
// flagged by is_last_o. busy stays high after each accept while a hold
// counter runs down, so rectangles are taken no faster than the single
// vertex multiply stage, which turns out one corner per cycle, can emit their
// four corners. The angle path (reduction, quadrant split, radian scaling, one
// register per CORDIC step, quadrant swap) is fully pipelined. Results cannot
// be held off by the receiver.
module rotated_rect_vertices #(
  parameter int CORDIC_STEPS   = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rrv_pkg::COORD_W-1:0]   corner_x_i,
  input  logic signed [rrv_pkg::COORD_W-1:0]   corner_y_i,
  input  logic        [rrv_pkg::SIZE_W-1:0]    rect_width_i,
  input  logic        [rrv_pkg::SIZE_W-1:0]    rect_height_i,
  input  logic signed [rrv_pkg::COORD_W-1:0]   pivot_dx_i,
  input  logic signed [rrv_pkg::COORD_W-1:0]   pivot_dy_i,
  input  logic signed [rrv_pkg::ANGLE_W-1:0]   angle_deg_i,
  output logic                                 vertex_valid_o,
  output logic signed [rrv_pkg::COORD_W-1:0]   vertex_x_o,
  output logic signed [rrv_pkg::COORD_W-1:0]   vertex_y_o,
  output logic        [1:0]                    vertex_index_o,
  output logic                                 is_last_o
);
  import rrv_pkg::*;

  localparam int F   = TRIG_FRAC_BITS;
  localparam int XW  = F + 3;
  localparam int PW  = XW + LOC_W;
  localparam int SW  = PW + 2;
  localparam longint X0 = (GAIN_Q30 + (64'sd1 <<< (29 - F))) >>> (30 - F);
  localparam logic signed [XW-1:0] X_INIT = XW'(X0);
  localparam logic signed [SW-1:0] HALF   = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd8388607);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd8388608);

  logic accept;
  assign accept = start && !busy;

  // Input throttle: a down-counter holds busy high after each accept
  logic [1:0] hold_cnt_q, hold_cnt_d;
  assign busy = (hold_cnt_q != 2'd0);
  always_comb begin
    hold_cnt_d = hold_cnt_q;
    if (accept) begin
      hold_cnt_d = 2'd3;
    end else if (hold_cnt_q != 2'd0) begin
      hold_cnt_d = hold_cnt_q - 2'd1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt_q <= '0;
    end else begin
      hold_cnt_q <= hold_cnt_d;
    end
  end

  // Stage 1: angle mod 360 and local geometry
  logic signed [ANGLE_W+1:0] a0, a1, a2;
  logic [14:0]  ared_d, ared_q;
  geom_t        geom_d;
  geom_t        geom1_q, geom2_q, geom3_q;
  logic         v1_q, v2_q, v3_q;
  always_comb begin
    a0 = (ANGLE_W+2)'(angle_deg_i);
    a1 = a0[ANGLE_W+1] ? a0 + (ANGLE_W+2)'(TURN_Q6) : a0;
    a2 = a1[ANGLE_W+1] ? a1 + (ANGLE_W+2)'(TURN_Q6) : a1;
    if (a2 >= (ANGLE_W+2)'(TURN_Q6)) begin
      a2 = a2 - (ANGLE_W+2)'(TURN_Q6);
    end
    ared_d = a2[14:0];
    geom_d.ox   = LOC_W'(corner_x_i) + LOC_W'(pivot_dx_i);
    geom_d.oy   = LOC_W'(corner_y_i) + LOC_W'(pivot_dy_i);
    geom_d.lx_l = -LOC_W'(pivot_dx_i);
    geom_d.lx_r = $signed({2'b00, rect_width_i}) - LOC_W'(pivot_dx_i);
    geom_d.ly_b = -LOC_W'(pivot_dy_i);
    geom_d.ly_t = $signed({2'b00, rect_height_i}) - LOC_W'(pivot_dy_i);
  end

  // Stage 2: quadrant and rest
  logic [1:0]  quad_d, quad2_q, quad3_q;
  logic [12:0] rest_d, rest_q;
  always_comb begin
    if (ared_q >= 15'(3 * QUARTER_Q6)) begin
      quad_d = 2'd3;
      rest_d = 13'(ared_q - 15'(3 * QUARTER_Q6));
    end else if (ared_q >= 15'(2 * QUARTER_Q6)) begin
      quad_d = 2'd2;
      rest_d = 13'(ared_q - 15'(2 * QUARTER_Q6));
    end else if (ared_q >= 15'(QUARTER_Q6)) begin
      quad_d = 2'd1;
      rest_d = 13'(ared_q - 15'(QUARTER_Q6));
    end else begin
      quad_d = 2'd0;
      rest_d = 13'(ared_q);
    end
  end

  // Stage 3: rest to Q30 radians
  logic [31:0] zrad, z3_q;
  assign zrad = 32'(rest_q) * 32'(DEG_TO_RAD_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    ared_q  <= ared_d;
    geom1_q <= geom_d;
    quad2_q <= quad_d;
    rest_q  <= rest_d;
    geom2_q <= geom1_q;
    quad3_q <= quad2_q;
    z3_q    <= zrad;
    geom3_q <= geom2_q;
  end

  // CORDIC pipeline, one register per step
  logic signed [XW-1:0]  cx_q [CORDIC_STEPS+1];
  logic signed [XW-1:0]  cy_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] cz_q [CORDIC_STEPS+1];
  logic [1:0]            cq_q [CORDIC_STEPS+1];
  geom_t                 cg_q [CORDIC_STEPS+1];
  logic                  cv_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    cx_q[0] <= X_INIT;
    cy_q[0] <= '0;
    cz_q[0] <= $signed({1'b0, z3_q});
    cq_q[0] <= quad3_q;
    cg_q[0] <= geom3_q;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0]  dx, dy;
    logic signed [Z_W-1:0] at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = $signed({2'b00, atan_q30(i)});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (!cz_q[i][Z_W-1]) begin
        cx_q[i+1] <= cx_q[i] - dx;
        cy_q[i+1] <= cy_q[i] + dy;
        cz_q[i+1] <= cz_q[i] - at;
      end else begin
        cx_q[i+1] <= cx_q[i] + dx;
        cy_q[i+1] <= cy_q[i] - dy;
        cz_q[i+1] <= cz_q[i] + at;
      end
      cq_q[i+1] <= cq_q[i];
      cg_q[i+1] <= cg_q[i];
    end
  end

  // Quadrant swap
  logic signed [XW-1:0] cos_d, sin_d, cos_q, sin_q;
  geom_t sg_q;
  logic  sv_q;
  always_comb begin
    case (cq_q[CORDIC_STEPS])
      2'd0: begin
        cos_d = cx_q[CORDIC_STEPS];
        sin_d = cy_q[CORDIC_STEPS];
      end
      2'd1: begin
        cos_d = -cy_q[CORDIC_STEPS];
        sin_d = cx_q[CORDIC_STEPS];
      end
      2'd2: begin
        cos_d = -cx_q[CORDIC_STEPS];
        sin_d = -cy_q[CORDIC_STEPS];
      end
      default: begin
        cos_d = cy_q[CORDIC_STEPS];
        sin_d = -cx_q[CORDIC_STEPS];
      end
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= cv_q[CORDIC_STEPS];
    end
  end
  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
    sg_q  <= cg_q[CORDIC_STEPS];
  end

  // Corner serializer: holds one rectangle, steps through four corners
  logic                 ser_act_q;
  logic [1:0]           ser_idx_q;
  logic signed [XW-1:0] hc_q, hs_q;
  geom_t                hg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_act_q <= 1'b0;
      ser_idx_q <= VTX_LT;
    end else if (sv_q) begin
      ser_act_q <= 1'b1;
      ser_idx_q <= VTX_LT;
    end else if (ser_act_q) begin
      ser_act_q <= (ser_idx_q != VTX_RB);
      ser_idx_q <= ser_idx_q + 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      hc_q <= cos_q;
      hs_q <= sin_q;
      hg_q <= sg_q;
    end
  end

  // Multiply stage
  logic signed [LOC_W-1:0] lx, ly;
  logic signed [PW-1:0]    pcx_q, psy_q, psx_q, pcy_q;
  logic signed [LOC_W-1:0] mox_q, moy_q;
  logic                    mv_q;
  logic [1:0]              midx_q;
  always_comb begin
    lx = (ser_idx_q == VTX_LT || ser_idx_q == VTX_LB) ? hg_q.lx_l : hg_q.lx_r;
    ly = (ser_idx_q == VTX_LT || ser_idx_q == VTX_RT) ? hg_q.ly_t : hg_q.ly_b;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= ser_act_q;
    end
  end
  always_ff @(posedge clk_i) begin
    pcx_q  <= PW'(hc_q) * PW'(lx);
    psy_q  <= PW'(hs_q) * PW'(ly);
    psx_q  <= PW'(hs_q) * PW'(lx);
    pcy_q  <= PW'(hc_q) * PW'(ly);
    mox_q  <= hg_q.ox;
    moy_q  <= hg_q.oy;
    midx_q <= ser_idx_q;
  end

  // Round, add pivot, saturate
  logic signed [SW-1:0] rx, ry, vx, vy;
  logic signed [COORD_W-1:0] sx, sy;
  always_comb begin
    rx = SW'(pcx_q) - SW'(psy_q) + HALF;
    ry = SW'(psx_q) + SW'(pcy_q) + HALF;
    vx = (rx >>> F) + SW'(mox_q);
    vy = (ry >>> F) + SW'(moy_q);
    if (vx > SAT_HI) begin
      sx = COORD_W'(SAT_HI);
    end else if (vx < SAT_LO) begin
      sx = COORD_W'(SAT_LO);
    end else begin
      sx = COORD_W'(vx);
    end
    if (vy > SAT_HI) begin
      sy = COORD_W'(SAT_HI);
    end else if (vy < SAT_LO) begin
      sy = COORD_W'(SAT_LO);
    end else begin
      sy = COORD_W'(vy);
    end
  end

  // Output word
  logic signed [COORD_W-1:0] vxo_q, vyo_q;
  logic [1:0] vidx_q;
  logic       vval_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vval_q <= 1'b0;
    end else begin
      vval_q <= mv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    vxo_q  <= sx;
    vyo_q  <= sy;
    vidx_q <= midx_q;
  end

  assign vertex_valid_o = vval_q;
  assign vertex_x_o     = vxo_q;
  assign vertex_y_o     = vyo_q;
  assign vertex_index_o = vidx_q;
  assign is_last_o      = (vidx_q == VTX_RB);

endmodule

>>> rtl/rrv_checker.sv
`include "assert_macros.svh"

module rrv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       vertex_valid_o,
  input logic [1:0] vertex_index_o,
  input logic       is_last_o
);
  import rrv_pkg::*;

  // Throttle: busy follows every taken word
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)

  // Corners come as an unbroken run of four
  `ASSERT_NXT(a_corner_run, clk_i, rst_ni, vertex_valid_o && !is_last_o,
              vertex_valid_o && vertex_index_o == $past(vertex_index_o) + 2'd1)

  // Last flag marks exactly the right-bottom corner
  `ASSERT_IMP(a_last_flag, clk_i, rst_ni, vertex_valid_o,
              is_last_o == (vertex_index_o == VTX_RB))

  // A run opens with the left-top corner
  `ASSERT_NXT(a_run_start, clk_i, rst_ni, !vertex_valid_o || is_last_o,
              !vertex_valid_o || vertex_index_o == VTX_LT)

endmodule

bind rotated_rect_vertices rrv_checker u_rrv_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rrv_pkg::*;

  localparam int STEPS = 16;
  localparam int FRAC  = 16;
  localparam int LATENCY = STEPS + 12;

  // Rectangle word
  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [SIZE_W-1:0]  w;
    logic        [SIZE_W-1:0]  h;
    logic signed [COORD_W-1:0] pdx;
    logic signed [COORD_W-1:0] pdy;
    logic signed [ANGLE_W-1:0] ang;
  } rect_t;

  // Corner word
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [1:0]         idx;
    logic                      last;
  } corner_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] corner_x_i = '0, corner_y_i = '0;
  logic [SIZE_W-1:0] rect_width_i = '0, rect_height_i = '0;
  logic signed [COORD_W-1:0] pivot_dx_i = '0, pivot_dy_i = '0;
  logic signed [ANGLE_W-1:0] angle_deg_i = '0;
  logic vertex_valid_o;
  logic signed [COORD_W-1:0] vertex_x_o, vertex_y_o;
  logic [1:0] vertex_index_o;
  logic is_last_o;

  corner_t pending_corners[$];
  int errors = 0;

  rotated_rect_vertices #(.CORDIC_STEPS(STEPS), .TRIG_FRAC_BITS(FRAC)) dut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Fixed-point sine/cosine of a Q.6 degree angle
  function automatic void trig_q(input logic signed [ANGLE_W-1:0] ang,
                                 output longint c, output longint s);
    longint a, quad, rest, x, y, z, dx, dy;
    a = longint'(ang) % longint'(TURN_Q6);
    if (a < 0) a += longint'(TURN_Q6);
    quad = a / longint'(QUARTER_Q6);
    rest = a - quad * longint'(QUARTER_Q6);
    z = rest * 292818;
    x = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    case (quad)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[COORD_W-1:0];
  endfunction

  // Expected four corners of one rectangle
  task automatic predict_corners(input rect_t r);
    longint c, s, ox, oy, lx, ly, rx, ry, half;
    corner_t e;
    trig_q(r.ang, c, s);
    half = 64'sd1 <<< (FRAC - 1);
    ox = longint'(r.cx) + longint'(r.pdx);
    oy = longint'(r.cy) + longint'(r.pdy);
    for (int k = 0; k < 4; k++) begin
      lx = (k % 2 == 1) ? longint'(r.w) - longint'(r.pdx) : -longint'(r.pdx);
      ly = (k < 2) ? longint'(r.h) - longint'(r.pdy) : -longint'(r.pdy);
      rx = c * lx - s * ly;
      ry = s * lx + c * ly;
      e.x = clamp_coord(floor_shr(rx + half, FRAC) + ox);
      e.y = clamp_coord(floor_shr(ry + half, FRAC) + oy);
      e.idx = k[1:0];
      e.last = (k == 3);
      pending_corners.push_back(e);
    end
  endtask

  // Corner checker
  always @(posedge clk_i) begin
    corner_t e;
    if (rst_ni && vertex_valid_o) begin
      if (pending_corners.size() == 0) begin
        $display("%0t: unexpected corner x=%0d y=%0d", $time, vertex_x_o, vertex_y_o);
        errors++;
      end else begin
        e = pending_corners.pop_front();
        if (vertex_x_o !== e.x || vertex_y_o !== e.y || vertex_index_o !== e.idx ||
            is_last_o !== e.last) begin
          $display("%0t: corner mismatch exp x=%0d y=%0d i=%0d l=%0d act x=%0d y=%0d i=%0d l=%0d",
                   $time, e.x, e.y, e.idx, e.last,
                   vertex_x_o, vertex_y_o, vertex_index_o, is_last_o);
          errors++;
        end
      end
    end
  end

  // Issue one rectangle word after a random gap
  task automatic send_rect(input rect_t r, input bit typed_check, input corner_t typed_lt);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    corner_x_i <= r.cx; corner_y_i <= r.cy;
    rect_width_i <= r.w; rect_height_i <= r.h;
    pivot_dx_i <= r.pdx; pivot_dy_i <= r.pdy;
    angle_deg_i <= r.ang;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_corners(r);
    // cross-check of a hand value for the first corner
    if (typed_check && (pending_corners[pending_corners.size() - 4].x !== typed_lt.x ||
        pending_corners[pending_corners.size() - 4].y !== typed_lt.y)) begin
      $display("%0t: hand value mismatch exp x=%0d y=%0d act x=%0d y=%0d", $time,
               typed_lt.x, typed_lt.y, pending_corners[pending_corners.size() - 4].x,
               pending_corners[pending_corners.size() - 4].y);
      errors++;
    end
  endtask

  function automatic rect_t rand_rect();
    rect_t r;
    r.cx = COORD_W'($urandom); r.cy = COORD_W'($urandom);
    r.w = SIZE_W'($urandom); r.h = SIZE_W'($urandom);
    r.pdx = COORD_W'($urandom); r.pdy = COORD_W'($urandom);
    r.ang = ANGLE_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // moderate geometry, away from saturation
      r.cx = COORD_W'(int'($urandom_range(0, 65535)) - 32768);
      r.cy = COORD_W'(int'($urandom_range(0, 65535)) - 32768);
      r.w = SIZE_W'($urandom_range(0, 20000)); r.h = SIZE_W'($urandom_range(0, 20000));
      r.pdx = COORD_W'(int'($urandom_range(0, 20000)) - 10000);
      r.pdy = COORD_W'(int'($urandom_range(0, 20000)) - 10000);
    end
    return r;
  endfunction

  typedef struct {
    rect_t   r;
    bit      typed;
    corner_t lt;
  } stim_row_t;

  stim_row_t stim_table[$];

  initial begin
    stim_row_t row;
    corner_t none;
    rect_t r;
    int drain;
    none = '{default: '0};
    // directed rows: zero, identity, extremes, quadrants, multi-turn, negative
    row = '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, VTX_LT, 0}}; stim_table.push_back(row);
    row = '{'{256, 512, 1024, 2048, 0, 0, 0}, 1, '{256, 2560, VTX_LT, 0}};
    stim_table.push_back(row);
    row = '{'{24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 0, 0, 0}, 0, none};
    stim_table.push_back(row);
    row = '{'{-24'sh800000, -24'sh800000, 0, 0, 0, 0, 0}, 1,
            '{-24'sh800000, -24'sh800000, VTX_LT, 0}};
    stim_table.push_back(row);
    for (int a = -3; a <= 8; a++) begin
      row = '{'{1000, -2000, 3000, 1500, 700, -400, 16'(a * 5760)}, 0, none};
      stim_table.push_back(row);
    end
    row = '{'{0, 0, 23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF, -24'sh800000, 16'sh7FFF}, 0, none};
    stim_table.push_back(row);
    row = '{'{-24'sh800000, 24'sh7FFFFF, 23'h7FFFFF, 0, -24'sh800000, 24'sh7FFFFF,
            -16'sh8000}, 0, none};
    stim_table.push_back(row);
    row = '{'{5, 5, 100, 100, 50, 50, 16'sd2880}, 0, none}; stim_table.push_back(row);
    row = '{'{5, 5, 100, 100, 50, 50, -16'sd1}, 0, none}; stim_table.push_back(row);
    row = '{'{5, 5, 100, 100, 50, 50, 16'sd23040}, 0, none}; stim_table.push_back(row);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send_rect(stim_table[i].r, stim_table[i].typed, stim_table[i].lt);
    for (int n = 0; n < 300; n++) begin
      r = rand_rect();
      send_rect(r, 0, none);
    end
    start <= 1'b0;

    drain = 0;
    while (pending_corners.size() != 0 && drain < 10000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && pending_corners.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rrv_pkg.sv
rtl/rotated_rect_vertices.sv
rtl/rrv_checker.sv
dv/tb.sv
